>>> rtl/core/kct_pkg.sv
// Shared types, constants and helper functions of the constant-velocity tracker.
// Used by every module of the block; depends on nothing else.
package kct_pkg;

  localparam int unsigned COORD_BITS    = 10;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned OUT_BITS      = COORD_BITS + 2;
  localparam int unsigned WORD_BITS     = 32;
  localparam int unsigned PROD_BITS     = 2 * WORD_BITS;
  localparam int unsigned ACC_BITS      = PROD_BITS + 3;
  localparam int unsigned NUM_COV       = 10;
  localparam int unsigned NUM_GAIN      = 8;
  localparam int unsigned PNOISE_BITS   = 16;
  localparam int unsigned MNOISE_BITS   = 24;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 24;
  localparam int unsigned STEP_BITS     = 6;

  // Multiply steps: determinant, gain numerators, state update, covariance update.
  localparam logic [STEP_BITS-1:0] GAIN_FIRST = 6'd2;
  localparam logic [STEP_BITS-1:0] UPD_FIRST  = 6'd18;
  localparam logic [STEP_BITS-1:0] COV_FIRST  = 6'd26;
  localparam logic [STEP_BITS-1:0] LAST_STEP  = 6'd45;

  localparam logic [COORD_BITS-1:0]  INIT_X_RST = 10'd400;
  localparam logic [COORD_BITS-1:0]  INIT_Y_RST = 10'd300;
  localparam logic [PNOISE_BITS-1:0] PNOISE_RST = 16'd66;
  localparam logic [MNOISE_BITS-1:0] MNOISE_RST = 24'd6554;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INIT_X = 2'd0,
    REG_INIT_Y = 2'd1,
    REG_PNOISE = 2'd2,
    REG_MNOISE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] meas_x;
    logic [COORD_BITS-1:0] meas_y;
  } meas_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] est_x;
    logic signed [OUT_BITS-1:0] est_y;
  } est_t;

  // Upper-triangle storage slot of covariance element (row, col).
  function automatic logic [3:0] cidx(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] r;
    case ({row, col})
      4'b0000: r = 4'd0;
      4'b0001, 4'b0100: r = 4'd1;
      4'b0010, 4'b1000: r = 4'd2;
      4'b0011, 4'b1100: r = 4'd3;
      4'b0101: r = 4'd4;
      4'b0110, 4'b1001: r = 4'd5;
      4'b0111, 4'b1101: r = 4'd6;
      4'b1010: r = 4'd7;
      4'b1011, 4'b1110: r = 4'd8;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cov_row(input logic [3:0] m);
    logic [1:0] r;
    case (m)
      4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
      4'd4, 4'd5, 4'd6: r = 2'd1;
      4'd7, 4'd8: r = 2'd2;
      default: r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cov_col(input logic [3:0] m);
    logic [1:0] r;
    case (m)
      4'd0: r = 2'd0;
      4'd1, 4'd4: r = 2'd1;
      4'd2, 4'd5, 4'd7: r = 2'd2;
      default: r = 2'd3;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to a 32-bit word.
  function automatic logic signed [WORD_BITS-1:0] sat32(input logic signed [ACC_BITS-1:0] v);
    logic signed [WORD_BITS-1:0] r;
    if (!v[ACC_BITS-1] && (|v[ACC_BITS-2:WORD_BITS-1])) begin
      r = {1'b0, {(WORD_BITS-1){1'b1}}};
    end else if (v[ACC_BITS-1] && !(&v[ACC_BITS-2:WORD_BITS-1])) begin
      r = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/kalman_tracker_const_velocity_2d.sv
// Channel  Signals                         Direction  Word
// in       in_valid_i/in_ready_o/in_data_i  input      meas_t (meas_x, meas_y)
// out      out_valid_o/out_ready_i/out_data_o output   est_t (est_x, est_y)
// cfg      cfg_we_i/cfg_idx_i/cfg_data_i    input      one register write
//
// One word passes through its accept in the idle state, a predict state, an innovation
// setup state, 46 multiply steps on the shared multiplier, and up to eight gain divides
// on the bit-serial divider. The input is ready only in the idle state. A
// finished estimate sits in the output register, so the next word can be taken
// while it waits; the block stalls at the end of that next word until the
// register is free.
// Reset is asynchronous; state and covariance clear to zero.
// Depends on kct_pkg, kct_mul and kct_div.
module kalman_tracker_const_velocity_2d #(
  parameter int unsigned FRAC_BITS = kct_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  kct_pkg::meas_t                     in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output kct_pkg::est_t                      out_data_o,
  input  logic                               cfg_we_i,
  input  logic [kct_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [kct_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import kct_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PRED  = 7'b0000010,
    ST_SPREP = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_ACC   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;

  state_e state_q;
  logic [STEP_BITS-1:0] step_q;
  logic started_q;

  logic [COORD_BITS-1:0]  init_x_q, init_y_q;
  logic [PNOISE_BITS-1:0] pnoise_q;
  logic [MNOISE_BITS-1:0] mnoise_q;

  meas_t meas_q;
  word_t sv_q [4];
  word_t cov_q [NUM_COV];
  word_t n_q [NUM_COV];
  word_t n_d [NUM_COV];
  word_t xp_q [4];
  word_t y_q [2];
  word_t k_q [NUM_GAIN];
  word_t s00_q, s11_q, s01;
  acc_t  detq_q, acc_q, acc_d, base, term, psum;
  logic  detz;

  word_t op_a, op_b;
  logic  shift_en, sub_en, first;
  logic [3:0] g_gain;
  logic [2:0] g_upd;
  logic [4:0] g_cov;
  logic [1:0] ri, cj;
  logic [2:0] kidx;

  logic signed [PROD_BITS-1:0] prod;
  logic  div_start, div_done;
  word_t div_quot;

  logic  out_valid_q;
  est_t  out_q;
  est_t  est_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_x_q <= INIT_X_RST;
      init_y_q <= INIT_Y_RST;
      pnoise_q <= PNOISE_RST;
      mnoise_q <= MNOISE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_INIT_X: init_x_q <= cfg_data_i[COORD_BITS-1:0];
        REG_INIT_Y: init_y_q <= cfg_data_i[COORD_BITS-1:0];
        REG_PNOISE: pnoise_q <= cfg_data_i[PNOISE_BITS-1:0];
        REG_MNOISE: mnoise_q <= cfg_data_i[MNOISE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Predicted covariance A P A^T + Q, all ten entries side by side.
  always_comb begin
    acc_t sum;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (i <= j) begin
          sum = ACC_BITS'(cov_q[cidx(2'(i), 2'(j))]);
          if (i < 2) sum = sum + ACC_BITS'(cov_q[cidx(2'(i + 2), 2'(j))]);
          if (j < 2) sum = sum + ACC_BITS'(cov_q[cidx(2'(i), 2'(j + 2))]);
          if (i < 2 && j < 2) sum = sum + ACC_BITS'(cov_q[cidx(2'(i + 2), 2'(j + 2))]);
          if (i == j) sum = sum + ACC_BITS'(pnoise_q);
          n_d[cidx(2'(i), 2'(j))] = sat32(sum);
        end
      end
    end
  end

  assign s01 = n_q[1];

  // Operand and accumulate control for the current multiply step.
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    shift_en = 1'b0;
    sub_en   = 1'b0;
    base     = '0;
    ri       = '0;
    cj       = '0;
    g_gain   = 4'(step_q - GAIN_FIRST);
    g_upd    = 3'(step_q - UPD_FIRST);
    g_cov    = 5'(step_q - COV_FIRST);
    if (step_q < GAIN_FIRST) begin
      op_a   = step_q[0] ? s01 : s00_q;
      op_b   = step_q[0] ? s01 : s11_q;
      sub_en = step_q[0];
    end else if (step_q < UPD_FIRST) begin
      ri     = g_gain[3:2];
      sub_en = g_gain[0];
      case (g_gain[1:0])
        2'd0: begin op_a = n_q[cidx(ri, 2'd0)]; op_b = s11_q; end
        2'd1: begin op_a = n_q[cidx(ri, 2'd1)]; op_b = s01;   end
        2'd2: begin op_a = n_q[cidx(ri, 2'd1)]; op_b = s00_q; end
        default: begin op_a = n_q[cidx(ri, 2'd0)]; op_b = s01; end
      endcase
    end else if (step_q < COV_FIRST) begin
      ri       = g_upd[2:1];
      op_a     = k_q[{ri, g_upd[0]}];
      op_b     = g_upd[0] ? y_q[1] : y_q[0];
      shift_en = 1'b1;
      base     = ACC_BITS'(xp_q[ri]);
    end else begin
      ri       = cov_row(g_cov[4:1]);
      cj       = cov_col(g_cov[4:1]);
      op_a     = k_q[{ri, g_cov[0]}];
      op_b     = n_q[cidx({1'b0, g_cov[0]}, cj)];
      shift_en = 1'b1;
      sub_en   = 1'b1;
      base     = ACC_BITS'(n_q[cidx(ri, cj)]);
    end
  end

  assign first = !step_q[0];
  assign psum  = ACC_BITS'(prod);
  assign term  = shift_en ? (psum >>> FRAC_BITS) : psum;
  assign acc_d = (first ? base : acc_q) + (sub_en ? -term : term);
  assign detz  = (detq_q == '0);
  assign kidx  = g_gain[3:1];

  kct_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (state_q == ST_MUL),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  assign div_start = (state_q == ST_ACC) && !first && (step_q >= GAIN_FIRST) &&
                     (step_q < UPD_FIRST) && !detz;

  kct_div #(.W(ACC_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_d),
    .divisor_i  (detq_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Estimate: truncate toward zero, then saturate to the output range.
  always_comb begin
    logic [WORD_BITS:0]        mag0, mag1;
    logic signed [WORD_BITS+1:0] q0, q1;
    mag0 = sv_q[0][WORD_BITS-1] ? -{1'b1, sv_q[0]} : {1'b0, sv_q[0]};
    mag1 = sv_q[1][WORD_BITS-1] ? -{1'b1, sv_q[1]} : {1'b0, sv_q[1]};
    mag0 = mag0 >> FRAC_BITS;
    mag1 = mag1 >> FRAC_BITS;
    q0 = sv_q[0][WORD_BITS-1] ? -(WORD_BITS+2)'(mag0) : (WORD_BITS+2)'(mag0);
    q1 = sv_q[1][WORD_BITS-1] ? -(WORD_BITS+2)'(mag1) : (WORD_BITS+2)'(mag1);
    if (!q0[WORD_BITS+1] && (|q0[WORD_BITS:OUT_BITS-1])) begin
      est_d.est_x = {1'b0, {(OUT_BITS-1){1'b1}}};
    end else if (q0[WORD_BITS+1] && !(&q0[WORD_BITS:OUT_BITS-1])) begin
      est_d.est_x = {1'b1, {(OUT_BITS-1){1'b0}}};
    end else begin
      est_d.est_x = q0[OUT_BITS-1:0];
    end
    if (!q1[WORD_BITS+1] && (|q1[WORD_BITS:OUT_BITS-1])) begin
      est_d.est_y = {1'b0, {(OUT_BITS-1){1'b1}}};
    end else if (q1[WORD_BITS+1] && !(&q1[WORD_BITS:OUT_BITS-1])) begin
      est_d.est_y = {1'b1, {(OUT_BITS-1){1'b0}}};
    end else begin
      est_d.est_y = q1[OUT_BITS-1:0];
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) sv_q[i] <= '0;
      for (int i = 0; i < NUM_COV; i++) cov_q[i] <= '0;
    end else begin
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (!started_q) begin
              sv_q[0]   <= sat32(ACC_BITS'(init_x_q) <<< FRAC_BITS);
              sv_q[1]   <= sat32(ACC_BITS'(init_y_q) <<< FRAC_BITS);
              sv_q[2]   <= '0;
              sv_q[3]   <= '0;
              started_q <= 1'b1;
            end
            state_q <= ST_PRED;
          end
        end
        ST_PRED:  state_q <= ST_SPREP;
        ST_SPREP: begin
          step_q  <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_ACC;
        ST_ACC: begin
          if (!first && step_q >= UPD_FIRST && step_q < COV_FIRST) begin
            sv_q[ri] <= sat32(acc_d);
          end
          if (!first && step_q >= COV_FIRST) begin
            cov_q[g_cov[4:1]] <= sat32(acc_d);
          end
          if (div_start) begin
            state_q <= ST_DIV;
          end else if (step_q == LAST_STEP) begin
            state_q <= ST_DONE;
          end else begin
            step_q  <= step_q + 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            step_q  <= step_q + 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Working registers of one step.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) meas_q <= in_data_i;
      end
      ST_PRED: begin
        for (int i = 0; i < NUM_COV; i++) n_q[i] <= n_d[i];
        xp_q[0] <= sat32(ACC_BITS'(sv_q[0]) + ACC_BITS'(sv_q[2]));
        xp_q[1] <= sat32(ACC_BITS'(sv_q[1]) + ACC_BITS'(sv_q[3]));
        xp_q[2] <= sv_q[2];
        xp_q[3] <= sv_q[3];
      end
      ST_SPREP: begin
        s00_q  <= sat32(ACC_BITS'(n_q[0]) + ACC_BITS'(mnoise_q));
        s11_q  <= sat32(ACC_BITS'(n_q[4]) + ACC_BITS'(mnoise_q));
        y_q[0] <= sat32((ACC_BITS'(meas_q.meas_x) <<< FRAC_BITS) - ACC_BITS'(xp_q[0]));
        y_q[1] <= sat32((ACC_BITS'(meas_q.meas_y) <<< FRAC_BITS) - ACC_BITS'(xp_q[1]));
      end
      ST_ACC: begin
        acc_q <= acc_d;
        if (step_q == GAIN_FIRST - 1'b1) begin
          detq_q <= acc_d >>> FRAC_BITS;
        end
        // A singular innovation gives a zero gain.
        if (!first && step_q >= GAIN_FIRST && step_q < UPD_FIRST && detz) begin
          k_q[kidx] <= '0;
        end
      end
      ST_DIV: begin
        if (div_done) k_q[kidx] <= div_quot;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) out_q <= est_d;
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/kct_mul.sv
// Shared signed 32x32 multiplier with a registered product.
// Depends on kct_pkg for word widths.
module kct_mul (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [kct_pkg::WORD_BITS-1:0]   a_i,
  input  logic signed [kct_pkg::WORD_BITS-1:0]   b_i,
  output logic signed [kct_pkg::PROD_BITS-1:0]   prod_o
);
  import kct_pkg::*;

  logic signed [PROD_BITS-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_BITS'(a_i) * PROD_BITS'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/core/kct_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// The quotient is saturated to a 32-bit word. Depends on kct_pkg.
module kct_div #(
  parameter int unsigned W = kct_pkg::ACC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [W-1:0]                  dividend_i,
  input  logic signed [W-1:0]                  divisor_i,
  output logic                                 done_o,
  output logic signed [kct_pkg::WORD_BITS-1:0] quot_o
);
  import kct_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(W + 1);

  logic                busy_q, done_q, neg_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [W:0]          rem_q;
  logic [W-1:0]        quo_q, dsr_q;
  logic [W:0]          rem_sh, diff;
  logic                hi_pos, hi_neg;

  assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_BITS'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Magnitudes are taken up front; the sign is restored at the output.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);
      dsr_q <= divisor_i[W-1] ? W'(-divisor_i) : W'(divisor_i);
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_q <= diff;
      end else begin
        rem_q <= rem_sh;
      end
      quo_q <= {quo_q[W-2:0], !diff[W]};
    end
  end

  assign hi_pos = |quo_q[W-1:WORD_BITS-1];
  assign hi_neg = (|quo_q[W-1:WORD_BITS]) ||
                  (quo_q[WORD_BITS-1] && (|quo_q[WORD_BITS-2:0]));

  always_comb begin
    if (neg_q) begin
      quot_o = hi_neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : -quo_q[WORD_BITS-1:0];
    end else begin
      quot_o = hi_pos ? {1'b0, {(WORD_BITS-1){1'b1}}} : quo_q[WORD_BITS-1:0];
    end
  end

  assign done_o = done_q;

endmodule
